### sv/sha512_pkg.sv
// shared types, constants and a rotate function of the sha-512 hash engine
package sha512_pkg;

  localparam logic [7:0] PadMark = 8'h80;
  localparam int unsigned LenPosWords = 14;

  typedef logic [63:0] word_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_word;   // write wr_data into buffer at wr_idx
    logic [3:0] wr_idx;
    logic [1:0] wr_sel;      // see WrSel constants
    logic       init_round;  // copy chaining values to working vars
    logic       do_round;    // run one round
    logic [6:0] round_idx;
    logic       finish;      // add working vars into chaining values
    logic       reset_iv;    // chaining values back to initial values
    logic       len_add;     // add bits of current beat into length
    logic       len_clr;
  } sha512_cmd_t;

  localparam logic [1:0] WrSelData = 2'd0;
  localparam logic [1:0] WrSelZero = 2'd1;
  localparam logic [1:0] WrSelLenHi = 2'd2;
  localparam logic [1:0] WrSelLenLo = 2'd3;

  localparam word_t IvWords [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam word_t RoundConst [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic word_t ror64(word_t x, int unsigned n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction

endpackage

### sv/sha512_datapath.sv
// sha-512 datapath: block buffer as schedule window, round logic, chaining values, length
module sha512_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha512_pkg::sha512_cmd_t cmd,
  input  logic [63:0]            in_word,
  input  logic [6:0]             in_bits,
  input  logic [2:0]             rd_idx,
  output logic [63:0]            rd_word
);

  sha512_pkg::word_t w_r [16];
  sha512_pkg::word_t v_r [8];
  sha512_pkg::word_t h_r [8];
  logic [63:0] len_lo_r, len_hi_r;

  sha512_pkg::word_t wr_data, w_cur, w_new, t1, t2, s0, s1, e, a;
  logic [64:0] lo_sum;

  // write mux for the buffer
  always_comb begin
    unique case (cmd.wr_sel)
      sha512_pkg::WrSelData:  wr_data = in_word;
      sha512_pkg::WrSelZero:  wr_data = '0;
      sha512_pkg::WrSelLenHi: wr_data = len_hi_r;
      default:                wr_data = len_lo_r;
    endcase
  end

  // schedule, round terms and length sum: buffer acts as a 16-word window, new word replaces oldest
  always_comb begin
    w_cur = w_r[cmd.round_idx[3:0]];
    s0 = sha512_pkg::ror64(w_r[(cmd.round_idx[3:0] + 4'd1)], 1) ^
         sha512_pkg::ror64(w_r[(cmd.round_idx[3:0] + 4'd1)], 8) ^
         (w_r[(cmd.round_idx[3:0] + 4'd1)] >> 7);
    s1 = sha512_pkg::ror64(w_r[(cmd.round_idx[3:0] + 4'd14)], 19) ^
         sha512_pkg::ror64(w_r[(cmd.round_idx[3:0] + 4'd14)], 61) ^
         (w_r[(cmd.round_idx[3:0] + 4'd14)] >> 6);
    w_new = s1 + w_r[(cmd.round_idx[3:0] + 4'd9)] + s0 + w_r[cmd.round_idx[3:0]];
    if (cmd.round_idx >= 7'd16) begin
      w_cur = w_new;
    end
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (sha512_pkg::ror64(e, 14) ^ sha512_pkg::ror64(e, 18) ^
         sha512_pkg::ror64(e, 41)) + ((e & v_r[5]) ^ (~e & v_r[6])) +
         sha512_pkg::RoundConst[cmd.round_idx] + w_cur;
    t2 = (sha512_pkg::ror64(a, 28) ^ sha512_pkg::ror64(a, 34) ^ sha512_pkg::ror64(a, 39)) +
         ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    lo_sum = {1'b0, len_lo_r} + {58'd0, in_bits};
  end

  // buffer and working vars
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      w_r[cmd.wr_idx] <= wr_data;
    end else if (cmd.do_round && cmd.round_idx >= 7'd16) begin
      w_r[cmd.round_idx[3:0]] <= w_new;
    end
    if (cmd.init_round) begin
      v_r <= h_r;
    end else if (cmd.do_round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // chaining values and length counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_iv) begin
      h_r <= sha512_pkg::IvWords;
    end else if (cmd.finish) begin
      for (int j = 0; j < 8; j++) begin
        h_r[j] <= h_r[j] + v_r[j];
      end
    end
    if (!rst_n || cmd.len_clr) begin
      len_lo_r <= '0;
      len_hi_r <= '0;
    end else if (cmd.len_add) begin
      len_lo_r <= lo_sum[63:0];
      len_hi_r <= len_hi_r + {63'd0, lo_sum[64]};
    end
  end

  assign rd_word = h_r[rd_idx];

endmodule

### sv/sha512_ctrl.sv
// sha-512 controller: input beats, padding sequence, rounds, digest output
module sha512_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [63:0]             in_data_word,
  input  logic [3:0]              in_byte_count,
  input  logic                    in_last_word,
  output logic [63:0]             pad_word,
  output logic [6:0]              pad_bits,
  output sha512_pkg::sha512_cmd_t cmd,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_word_index,
  output logic                    out_digest_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_FILL, S_ROUND, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] widx_r, widx_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic       pad_r, pad_nxt;       // in padding after last beat
  logic       mark_r, mark_nxt;     // 0x80 still owed
  logic [2:0] oidx_r, oidx_nxt;
  logic       done_r, done_nxt;     // block just loaded carries the length
  logic       lenhi_r, lenhi_nxt;   // length high word went in last cycle
  logic [3:0] cnt;
  logic       acc;
  logic [63:0] keep;

  assign cnt = (in_byte_count > 4'd8 || !in_last_word) ? 4'd8 : in_byte_count;
  assign acc = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // full words pass through; a short last word is masked with the marker, or the lone marker word
  always_comb begin
    keep = (cnt == 4'd0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> {cnt, 3'b000});
    if (state_r == S_MARK) begin
      pad_word = {sha512_pkg::PadMark, 56'd0};
    end else begin
      pad_word = (cnt == 4'd8) ? in_data_word
               : ((in_data_word & keep) |
                  ({56'd0, sha512_pkg::PadMark} << (7'd56 - {cnt, 3'b000})));
    end
    pad_bits = {cnt, 3'b000};
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r; widx_nxt = widx_r; rnd_nxt = rnd_r;
    pad_nxt = pad_r; mark_nxt = mark_r; oidx_nxt = oidx_r;
    cmd = '0;
    cmd.round_idx = rnd_r;
    cmd.wr_idx = widx_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load_word = 1'b1;
          cmd.wr_sel = sha512_pkg::WrSelData;
          cmd.len_add = 1'b1;
          widx_nxt = widx_r + 4'd1;
          if (in_last_word) begin
            pad_nxt = 1'b1;
            mark_nxt = (cnt == 4'd8);
            state_nxt = (widx_r == 4'd15) ? S_ROUND : (cnt == 4'd8 ? S_MARK : S_FILL);
          end else if (widx_r == 4'd15) begin
            state_nxt = S_ROUND;
          end
          if (widx_r == 4'd15) begin
            cmd.init_round = 1'b1;
            rnd_nxt = '0;
          end
        end
      end
      S_MARK: begin
        cmd.load_word = 1'b1;
        cmd.wr_sel = sha512_pkg::WrSelData;
        mark_nxt = 1'b0;
        widx_nxt = widx_r + 4'd1;
        if (widx_r == 4'd15) begin
          cmd.init_round = 1'b1; rnd_nxt = '0; state_nxt = S_ROUND;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cmd.load_word = 1'b1;
        widx_nxt = widx_r + 4'd1;
        // length only in a block whose fill starts at or before position fourteen
        if (widx_r == 4'd14) cmd.wr_sel = sha512_pkg::WrSelLenHi;
        else if (widx_r == 4'd15 && lenhi_r) cmd.wr_sel = sha512_pkg::WrSelLenLo;
        else cmd.wr_sel = sha512_pkg::WrSelZero;
        if (widx_r == 4'd15) begin
          cmd.init_round = 1'b1; rnd_nxt = '0; state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          rnd_nxt = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (!pad_r) state_nxt = S_IDLE;
        else if (mark_r) state_nxt = S_MARK;
        else if (!done_r) state_nxt = S_FILL;
        else state_nxt = S_OUT;
        rnd_nxt = '0;
        oidx_nxt = '0;
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.reset_iv = 1'b1; cmd.len_clr = 1'b1;
            pad_nxt = 1'b0; widx_nxt = '0; state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // a block that ended with the length words finishes the message
  always_comb begin
    done_nxt = done_r;
    lenhi_nxt = (state_r == S_FILL && widx_r == 4'd14);
    if (state_r == S_FILL && widx_r == 4'd15 && lenhi_r) done_nxt = 1'b1;
    if (acc && in_last_word) done_nxt = 1'b0;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; widx_r <= '0; rnd_r <= '0; pad_r <= 1'b0;
      mark_r <= 1'b0; oidx_r <= '0; done_r <= 1'b0; lenhi_r <= 1'b0;
    end else begin
      state_r <= state_nxt; widx_r <= widx_nxt; rnd_r <= rnd_nxt; pad_r <= pad_nxt;
      mark_r <= mark_nxt; oidx_r <= oidx_nxt; done_r <= done_nxt; lenhi_r <= lenhi_nxt;
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_word_index = oidx_r;
  assign out_digest_last = (oidx_r == 3'd7);

endmodule

### sv/sha512_hash_engine.sv
// sha-512 hash engine top level
// one beat per cycle while the engine is idle; a sixteenth word starts 80 rounds, one per cycle,
// then a fold into the chaining values, and no beat is taken until the block is done
// after a last beat, padding blocks (marker, zeros, length words) get their rounds and fold,
// then eight digest beats follow, one per cycle when out_ready is high
// synchronous active-low reset restores initial hash values and clears the length
module sha512_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_last
);

  sha512_pkg::sha512_cmd_t cmd;
  logic [63:0] pad_word;
  logic [6:0]  pad_bits;

  sha512_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_word, .in_byte_count, .in_last_word,
    .pad_word, .pad_bits, .cmd, .out_valid, .out_ready, .out_word_index, .out_digest_last
  );

  sha512_datapath u_dp (
    .clk, .rst_n, .cmd, .in_word(pad_word), .in_bits(pad_bits),
    .rd_idx(out_word_index), .rd_word(out_digest_word)
  );

endmodule

### sv/sha512_checker.sv
// port-level checker for the sha-512 hash engine, bound to the top level
module sha512_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_word_index,
  input logic       out_digest_last
);

  // no input taken while digest is shown
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input ready during digest output");

  // last flag only on index seven
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digest_last == (out_word_index == 3'd7)))
    else $error("digest_last mismatch");

  // index steps by one after each beat
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_digest_last |=> out_valid &&
    out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest index skipped");

  // first digest word has index zero
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_word_index == 3'd0)
    else $error("digest does not start at zero");

endmodule

bind sha512_hash_engine sha512_checker u_chk (.*);

### verif/tb_sha512_hash_engine.sv
// self-checking testbench for the sha-512 hash engine
`timescale 1ns / 1ps

module tb_sha512_hash_engine;

  localparam int RandomItems = 360;
  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_digest_last;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } digest_beat_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } msg_beat_t;

  sha512_hash_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_word(in_data_word), .in_byte_count(in_byte_count),
    .in_last_word(in_last_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_digest_last(out_digest_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  sha512_pkg::word_t hash_state [8];
  sha512_pkg::word_t msg_block [16];
  int unsigned block_fill;
  logic [127:0] msg_bits;

  digest_beat_t digest_queue [$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  function automatic sha512_pkg::word_t rotr(sha512_pkg::word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_msg_block();
    sha512_pkg::word_t w [80];
    sha512_pkg::word_t v [8];
    sha512_pkg::word_t t1, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 80; i++)
      w[i] = (rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7] +
             (rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
    for (int j = 0; j < 8; j++) v[j] = hash_state[j];
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::RoundConst[i] + w[i];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] += t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] += v[j];
  endtask

  task automatic append_word(sha512_pkg::word_t w);
    msg_block[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_msg_block();
      block_fill = 0;
    end
  endtask

  task automatic restart_hash();
    for (int j = 0; j < 8; j++) hash_state[j] = sha512_pkg::IvWords[j];
    block_fill = 0;
    msg_bits = '0;
  endtask

  // predict digest beats for one accepted message beat
  task automatic predict_digest(msg_beat_t b);
    int unsigned n;
    sha512_pkg::word_t keep;
    digest_beat_t d;
    n = (b.byte_count > 8) ? 8 : b.byte_count;
    if (!b.last_word) begin
      msg_bits += 128'd64;
      append_word(b.data_word);
      return;
    end
    msg_bits += 128'(n * 8);
    if (n == 8) begin
      append_word(b.data_word);
      append_word({sha512_pkg::PadMark, 56'd0});
    end else begin
      keep = (n == 0) ? '0 : ~64'd0 << (64 - 8 * n);
      append_word((b.data_word & keep) |
                  (sha512_pkg::word_t'(sha512_pkg::PadMark) << (56 - 8 * n)));
    end
    if (block_fill > sha512_pkg::LenPosWords)
      while (block_fill != 0) append_word('0);
    while (block_fill < sha512_pkg::LenPosWords) append_word('0);
    append_word(msg_bits[127:64]);
    append_word(msg_bits[63:0]);
    for (int k = 0; k < 8; k++) begin
      d.digest_word = hash_state[k];
      d.word_index = 3'(k);
      d.digest_last = (k == 7);
      digest_queue.push_back(d);
    end
    restart_hash();
  endtask

  // send one beat, with random idle bursts before it
  task automatic send_beat(msg_beat_t b);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= b.data_word;
    in_byte_count <= b.byte_count;
    in_last_word <= b.last_word;
    do @(posedge clk); while (!in_ready);
    predict_digest(b);
  endtask

  // stop offering beats
  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic msg_beat_t mk(logic [63:0] d, logic [3:0] c, logic l);
    msg_beat_t b;
    b.data_word = d;
    b.byte_count = c;
    b.last_word = l;
    return b;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // result side: the check against the oldest expectation
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        $error("digest beat with nothing expected: %h", out_digest_word);
        errors++;
      end else begin
        exp_beat = digest_queue.pop_front();
        if (out_digest_word !== exp_beat.digest_word) begin
          $error("digest_word exp %h got %h", exp_beat.digest_word, out_digest_word);
          errors++;
        end
        if (out_word_index !== exp_beat.word_index) begin
          $error("word_index exp %0d got %0d", exp_beat.word_index, out_word_index);
          errors++;
        end
        if (out_digest_last !== exp_beat.digest_last) begin
          $error("digest_last exp %0d got %0d", exp_beat.digest_last, out_digest_last);
          errors++;
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!no_idle) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("sha512_hash_engine verification failed");
      $finish;
    end
  end

  // directed table; first word of the empty-string digest is typed in, all go through the predictor
  msg_beat_t dir_beats [] = '{
    mk(64'h0, 4'd0, 1'b1),                      // empty message
    mk(64'h6162630000000000, 4'd3, 1'b1),       // "abc"
    mk(64'hffffffffffffffff, 4'd8, 1'b1),       // full last word
    mk(64'hffffffffffffffff, 4'd15, 1'b1),      // count above eight
    mk(64'h0123456789abcdef, 4'd2, 1'b0),       // short word not last
    mk(64'hffffffffffffffff, 4'd7, 1'b1),       // unused bytes dropped
    mk(64'h0000000000000000, 4'd1, 1'b1),
    mk(64'h8000000000000001, 4'd4, 1'b1)
  };

  initial begin
    int words, sent;
    restart_hash();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_beats[i]) begin
      send_beat(dir_beats[i]);
      // empty message: first digest word is known
      if (i == 0 && digest_queue[0].digest_word !== 64'hcf83e1357eefb8bd) begin
        $error("digest_word exp %h got %h", 64'hcf83e1357eefb8bd,
               digest_queue[0].digest_word);
        errors++;
      end
    end

    // messages crossing the padding boundary: 13..17 words before the last
    for (int len = 13; len <= 17; len++) begin
      for (int i = 0; i < len; i++) send_beat(mk(rand_word(), 4'(i), 1'b0));
      send_beat(mk(rand_word(), 4'($urandom_range(0, 8)), 1'b1));
    end

    // sender waits until every digest beat is out
    drop_valid();
    while (digest_queue.size() != 0) @(posedge clk);

    // random messages, mostly short, a few long
    sent = 0;
    while (sent < RandomItems) begin
      if (sent > RandomItems * 4 / 5) no_idle = 1'b1;
      words = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 18);
      for (int i = 0; i < words; i++) begin
        send_beat(mk(rand_word(), 4'($urandom_range(0, 15)), 1'b0));
        sent++;
      end
      send_beat(mk(rand_word(), 4'($urandom_range(0, 15)), 1'b1));
      sent++;
    end

    drop_valid();
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && digest_queue.size() == 0)
      $display("sha512_hash_engine verification clean");
    else
      $display("sha512_hash_engine verification failed");
    $finish;
  end

endmodule

### filelist.f
sv/sha512_pkg.sv
sv/sha512_datapath.sv
sv/sha512_ctrl.sv
sv/sha512_hash_engine.sv
sv/sha512_checker.sv
verif/tb_sha512_hash_engine.sv
